// File: hdl/eitsp_pkg.sv
// eitsp_pkg: shared constants, phase and record-kind codes and the record struct
// for the eit section parser; no dependencies, compiled first
package eitsp_pkg;

  localparam int MAX_SECTION_BYTES_DEF = 4096;
  localparam int MIN_SECTION_BYTES     = 18;
  localparam int HDR_LEN               = 14;
  localparam int EVT_LEN               = 12;
  localparam int CRC_BYTES             = 4;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_EVENT  = 3'd2,
    PH_DTAG   = 3'd3,
    PH_DLEN   = 3'd4,
    PH_DBODY  = 3'd5,
    PH_CRC    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    K_HEADER = 3'd0,
    K_EVENT  = 3'd1,
    K_DESC   = 3'd2,
    K_CRC    = 3'd3,
    K_ERROR  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t        record_kind;
    logic [15:0]  id_value;
    logic [15:0]  stream_id;
    logic [15:0]  network_id;
    logic [7:0]   number_a;
    logic [7:0]   number_b;
    logic [7:0]   number_c;
    logic [7:0]   number_d;
    logic [5:0]   flag_bits;
    logic [39:0]  time_value;
    logic [23:0]  duration_value;
    logic [11:0]  loop_length;
  } rec_t;

endpackage

// File: hdl/eitsp_parser.sv
// eitsp_parser: byte-serial section state machine, one accepted byte per cycle,
// gives at most one record per byte; depends on eitsp_pkg
module eitsp_parser
  import eitsp_pkg::*;
#(
  parameter int MAX_SECTION_BYTES = MAX_SECTION_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_en,
  input  logic [7:0]  data_byte,
  input  logic        section_start,
  input  logic [12:0] section_length,
  output logic        res_valid,
  output rec_t        res
);

  localparam logic [12:0] MAX_LEN = 13'(MAX_SECTION_BYTES);
  localparam logic [12:0] MIN_LEN = 13'(MIN_SECTION_BYTES);
  localparam logic [12:0] HDR_LAST = 13'(HDR_LEN - 1);
  localparam logic [13:0] HDR_END = 14'(HDR_LEN);
  localparam logic [3:0]  EVT_LAST = 4'(EVT_LEN - 1);

  phase_t      phase_r, phase_nxt;
  logic [12:0] pos_r, pos_nxt;
  logic [12:0] tot_r, tot_nxt;
  logic [3:0]  ecnt_r, ecnt_nxt;
  logic [11:0] loop_r, loop_nxt;
  logic [7:0]  dleft_r, dleft_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [31:0] crc_r, crc_nxt;

  logic [7:0]  hdr_r [HDR_LEN];
  logic [7:0]  evt_r [EVT_LEN];
  logic        hdr_we, evt_we;
  logic [3:0]  hdr_idx;

  always_comb begin
    logic        go;
    logic [12:0] p;
    logic [12:0] crc_at;
    logic [13:0] p_inc;
    logic [11:0] loop_dec;
    logic [11:0] new_loop;
    phase_t      after_loop;

    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    tot_nxt   = tot_r;
    ecnt_nxt  = ecnt_r;
    loop_nxt  = loop_r;
    dleft_nxt = dleft_r;
    tag_nxt   = tag_r;
    crc_nxt   = crc_r;
    hdr_we    = 1'b0;
    evt_we    = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    go        = 1'b0;

    if (byte_en) begin
      if (section_start) begin
        tot_nxt   = section_length;
        pos_nxt   = '0;
        ecnt_nxt  = '0;
        loop_nxt  = '0;
        dleft_nxt = '0;
        crc_nxt   = '0;
        if (!(section_length inside {[MIN_LEN:MAX_LEN]})) begin
          res.record_kind = K_ERROR;
          res_valid       = 1'b1;
          phase_nxt       = PH_IDLE;
        end else begin
          phase_nxt = PH_HEADER;
          go        = 1'b1;
        end
      end else if (phase_r != PH_IDLE) begin
        go = 1'b1;
      end
    end

    p          = pos_nxt;
    crc_at     = tot_nxt - 13'(CRC_BYTES);
    p_inc      = {1'b0, p} + 14'd1;
    loop_dec   = loop_nxt - 12'd1;
    after_loop = (p_inc < {1'b0, crc_at}) ? PH_EVENT : PH_CRC;
    new_loop   = '0;
    hdr_idx    = p[3:0];

    if (go) begin
      pos_nxt = p_inc[12:0];
      if (phase_nxt == PH_HEADER) begin
        hdr_we = (p < 13'(HDR_LEN));
        if (p == HDR_LAST) begin
          res_valid          = 1'b1;
          res.record_kind    = K_HEADER;
          res.id_value       = {hdr_r[3], hdr_r[4]};
          res.stream_id      = {hdr_r[8], hdr_r[9]};
          res.network_id     = {hdr_r[10], hdr_r[11]};
          res.number_a       = hdr_r[6];
          res.number_b       = hdr_r[7];
          res.number_c       = hdr_r[12];
          res.number_d       = data_byte;
          res.flag_bits      = {hdr_r[5][5:1], hdr_r[5][0]};
          phase_nxt = (HDR_END < {1'b0, crc_at}) ? PH_EVENT : PH_CRC;
        end
      end else if (phase_nxt == PH_CRC) begin
        crc_nxt = {crc_r[23:0], data_byte};
        if (p_inc >= {1'b0, tot_nxt}) begin
          res_valid       = 1'b1;
          res.record_kind = K_CRC;
          res.time_value  = {8'd0, crc_nxt};
          phase_nxt       = PH_IDLE;
        end
      end else if (p >= crc_at) begin
        // loop or event header ran into the crc
        res_valid       = 1'b1;
        res.record_kind = K_ERROR;
        phase_nxt       = PH_IDLE;
      end else begin
        case (phase_nxt)
          PH_EVENT: begin
            evt_we   = 1'b1;
            ecnt_nxt = ecnt_r + 4'd1;
            if (ecnt_r == EVT_LAST) begin
              ecnt_nxt           = '0;
              new_loop           = {evt_r[10][3:0], data_byte};
              loop_nxt           = new_loop;
              res_valid          = 1'b1;
              res.record_kind    = K_EVENT;
              res.id_value       = {evt_r[0], evt_r[1]};
              res.flag_bits      = {2'b00, evt_r[10][7:5], evt_r[10][4]};
              res.time_value     = {evt_r[2], evt_r[3], evt_r[4], evt_r[5], evt_r[6]};
              res.duration_value = {evt_r[7], evt_r[8], evt_r[9]};
              res.loop_length    = new_loop;
              phase_nxt = (new_loop != '0) ? PH_DTAG : after_loop;
            end
          end
          PH_DTAG: begin
            tag_nxt  = data_byte;
            loop_nxt = loop_dec;
            if (loop_dec == '0) begin
              // tag is the last loop byte: length reads as zero
              res_valid       = 1'b1;
              res.record_kind = K_DESC;
              res.id_value    = {8'd0, data_byte};
              phase_nxt       = after_loop;
            end else begin
              phase_nxt = PH_DLEN;
            end
          end
          PH_DLEN: begin
            loop_nxt        = loop_dec;
            dleft_nxt       = data_byte;
            res_valid       = 1'b1;
            res.record_kind = K_DESC;
            res.id_value    = {8'd0, tag_r};
            res.number_a    = data_byte;
            if (loop_dec == '0) begin
              phase_nxt = after_loop;
            end else begin
              phase_nxt = (data_byte == '0) ? PH_DTAG : PH_DBODY;
            end
          end
          PH_DBODY: begin
            loop_nxt = loop_dec;
            if (dleft_r != '0) begin
              dleft_nxt = dleft_r - 8'd1;
            end
            if (loop_dec == '0) begin
              phase_nxt = after_loop;
            end else if (dleft_nxt == '0) begin
              phase_nxt = PH_DTAG;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      tot_r   <= '0;
      ecnt_r  <= '0;
      loop_r  <= '0;
      dleft_r <= '0;
      tag_r   <= '0;
      crc_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      tot_r   <= tot_nxt;
      ecnt_r  <= ecnt_nxt;
      loop_r  <= loop_nxt;
      dleft_r <= dleft_nxt;
      tag_r   <= tag_nxt;
      crc_r   <= crc_nxt;
    end
  end

  // header and event byte stores, written only in the running section
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[hdr_idx] <= data_byte;
    end
    if (evt_we) begin
      evt_r[ecnt_r] <= data_byte;
    end
  end

endmodule

// File: hdl/eit_section_parser_core.sv
// eit_section_parser_core: top level of the eit section parser, output register
// with skid stage around eitsp_parser; depends on eitsp_pkg and eitsp_parser
//
// channel  direction  handshake            payload
// in_      input      in_valid / in_ready  data_byte, section_start, section_length
// out_     output     out_valid/out_ready  one record: kind, ids, numbers, time, ...
//
// one byte is accepted per cycle while in_ready is high; the record a byte
// causes lands in the output register, or in the skid stage while out_ stalls
// the byte state machine is updated in the same cycle the byte is taken
// a stalled out_ parks one extra record in the skid stage; in_ready drops only
// while that stage is full
// rst_n is synchronous, active low; it returns the parser to idle and empties
// the output and skid stages
module eit_section_parser_core
  import eitsp_pkg::*;
#(
  parameter int MAX_SECTION_BYTES = MAX_SECTION_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_section_start,
  input  logic [12:0] in_section_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_record_kind,
  output logic [15:0] out_id_value,
  output logic [15:0] out_stream_id,
  output logic [15:0] out_network_id,
  output logic [7:0]  out_number_a,
  output logic [7:0]  out_number_b,
  output logic [7:0]  out_number_c,
  output logic [7:0]  out_number_d,
  output logic [5:0]  out_flag_bits,
  output logic [39:0] out_time_value,
  output logic [23:0] out_duration_value,
  output logic [11:0] out_loop_length
);

  logic in_fire;
  logic res_valid;
  rec_t res;

  logic out_valid_r, out_valid_nxt;
  rec_t out_rec_r, out_rec_nxt;
  logic skid_valid_r, skid_valid_nxt;
  rec_t skid_rec_r, skid_rec_nxt;

  // input side only waits when the skid stage already holds a record
  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;

  eitsp_parser #(
    .MAX_SECTION_BYTES (MAX_SECTION_BYTES)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_en        (in_fire),
    .data_byte      (in_data_byte),
    .section_start  (in_section_start),
    .section_length (in_section_length),
    .res_valid      (res_valid),
    .res            (res)
  );

  // output register plus skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_rec_nxt    = out_rec_r;
    skid_valid_nxt = skid_valid_r;
    skid_rec_nxt   = skid_rec_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        // drain the parked record first; no new record can arrive now
        out_valid_nxt  = 1'b1;
        out_rec_nxt    = skid_rec_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_rec_nxt   = res;
      end
    end else if (res_valid) begin
      // output stalled: park the fresh record
      skid_valid_nxt = 1'b1;
      skid_rec_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rec_r  <= out_rec_nxt;
    skid_rec_r <= skid_rec_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_record_kind    = out_rec_r.record_kind;
  assign out_id_value       = out_rec_r.id_value;
  assign out_stream_id      = out_rec_r.stream_id;
  assign out_network_id     = out_rec_r.network_id;
  assign out_number_a       = out_rec_r.number_a;
  assign out_number_b       = out_rec_r.number_b;
  assign out_number_c       = out_rec_r.number_c;
  assign out_number_d       = out_rec_r.number_d;
  assign out_flag_bits      = out_rec_r.flag_bits;
  assign out_time_value     = out_rec_r.time_value;
  assign out_duration_value = out_rec_r.duration_value;
  assign out_loop_length    = out_rec_r.loop_length;

`ifndef SYNTHESIS
  // the skid stage is only ever filled behind a held output record
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a record while output register is empty");

  // a record made while the output stalls must land in the skid stage
  a_stall_parks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && res_valid) |=> skid_valid_r)
    else $error("record lost while output stalled");

  // a parked record moves to the output as soon as the output is taken
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> (out_valid_r && !skid_valid_r))
    else $error("skid stage did not drain");
`endif

endmodule
